/* rtl/cq_pkg.sv */
// shared types and constants of the c-look request scheduler
package cq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int SECTOR_BITS = 48;
   localparam int TAG_BITS    = 8;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [SECTOR_BITS-1:0] sector;
      logic [TAG_BITS-1:0]    tag;
      logic                   is_write;
   } entry_type;

   typedef enum logic [1:0] {
      CMD_ADD      = 2'd0,
      CMD_DISPATCH = 2'd1,
      CMD_REMOVE   = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_ADDED      = 3'd0,
      ST_DISPATCHED = 3'd1,
      ST_EMPTY      = 3'd2,
      ST_FULL       = 3'd3,
      ST_NOT_FOUND  = 3'd4
   } status_type;

endpackage

/* rtl/cq_store.sv */
// queue entry memory, one write port and one registered read port
module cq_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [cq_pkg::IDX_BITS-1:0]    wr_addr,
   input  cq_pkg::entry_type              wr_data,
   input  logic                           rd_en,
   input  logic [cq_pkg::IDX_BITS-1:0]    rd_addr,
   output cq_pkg::entry_type              rd_data
);

   cq_pkg::entry_type mem_ff [cq_pkg::QUEUE_DEPTH];
   cq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/clook_request_scheduler.sv */
// top level of the c-look request scheduler
// The queue lives in a single-port-read memory and is walked one entry per
// clock by one comparator under a small sequencer, so the block takes one
// beat at a time and stalls its input while it works. An add scans to the
// insert point, moves the entries from there up by one place, then writes
// the new entry; if no entry belongs after it, the scan ends and the entry
// is written at the tail, and into an empty queue it is written straight
// away. A dispatch or remove scans, then moves the entries behind the hit
// down by one place. Refused and empty cases go straight to the result. A
// stalled result holds the block in its done state. A result
// waits in the output register while the next beat is accepted.
module clook_request_scheduler (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [cq_pkg::SECTOR_BITS-1:0]    req_sector,
   input  logic                              req_is_write,
   input  logic [cq_pkg::TAG_BITS-1:0]       req_tag,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [cq_pkg::TAG_BITS-1:0]       rsp_out_tag,
   output logic [cq_pkg::SECTOR_BITS-1:0]    rsp_out_sector,
   output logic                              rsp_out_is_write,
   output logic [cq_pkg::CNT_BITS-1:0]       rsp_occupancy
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DN,
      S_PLACE,
      S_DONE
   } state_type;

   state_type                         state_ff;
   cq_pkg::cmd_type                   cmd_ff;
   logic [cq_pkg::SECTOR_BITS-1:0]    sec_ff;
   logic                              wr_ff;
   logic [cq_pkg::TAG_BITS-1:0]       tag_ff;
   logic                              above_ff;
   logic [cq_pkg::CNT_BITS-1:0]       cnt_ff;
   logic [cq_pkg::SECTOR_BITS-1:0]    head_ff;
   logic [cq_pkg::CNT_BITS-1:0]       pos_ff;
   logic [cq_pkg::IDX_BITS-1:0]       rd_addr_ff;

   cq_pkg::status_type                res_status_ff;
   logic [cq_pkg::TAG_BITS-1:0]       res_tag_ff;
   logic [cq_pkg::SECTOR_BITS-1:0]    res_sector_ff;
   logic                              res_write_ff;
   logic [cq_pkg::CNT_BITS-1:0]       res_occ_ff;

   logic                              rsp_valid_ff;
   logic [2:0]                        rsp_status_ff;
   logic [cq_pkg::TAG_BITS-1:0]       rsp_tag_ff;
   logic [cq_pkg::SECTOR_BITS-1:0]    rsp_sector_ff;
   logic                              rsp_write_ff;
   logic [cq_pkg::CNT_BITS-1:0]       rsp_occ_ff;

   logic                              mem_wr_en;
   logic [cq_pkg::IDX_BITS-1:0]       mem_wr_addr;
   cq_pkg::entry_type                 mem_wr_data;
   logic                              mem_rd_en;
   logic [cq_pkg::IDX_BITS-1:0]       mem_rd_addr;
   cq_pkg::entry_type                 mem_rd_data;

   logic                              req_take;
   cq_pkg::cmd_type                   req_cmd;
   logic                              cnt_zero;
   logic                              cnt_full;
   logic [cq_pkg::CNT_BITS-1:0]       cnt_less;
   logic [cq_pkg::CNT_BITS-1:0]       cnt_more;
   logic                              scan_last;
   logic                              add_stop;
   logic                              scan_hit;
   logic                              start_scan;
   logic                              rsp_free;
   cq_pkg::entry_type                 new_entry;

   cq_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign req_cmd   = cq_pkg::cmd_type'(req_command);
   assign cnt_zero  = (cnt_ff == '0);
   assign cnt_full  = (cnt_ff == cq_pkg::CNT_BITS'(cq_pkg::QUEUE_DEPTH));
   assign cnt_less  = cnt_ff - cq_pkg::CNT_BITS'(1);
   assign cnt_more  = cnt_ff + cq_pkg::CNT_BITS'(1);
   assign scan_last = ({1'b0, rd_addr_ff} == cnt_less);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign new_entry.sector   = sec_ff;
   assign new_entry.tag      = tag_ff;
   assign new_entry.is_write = wr_ff;

   // c-look insert point: stop before an entry that belongs after the new one
   always_comb begin
      if (above_ff) begin
         add_stop = (mem_rd_data.sector < head_ff) || (mem_rd_data.sector > sec_ff);
      end else begin
         add_stop = (mem_rd_data.sector < head_ff) && (mem_rd_data.sector > sec_ff);
      end
   end

   always_comb begin
      case (cmd_ff)
         cq_pkg::CMD_ADD:      scan_hit = add_stop;
         cq_pkg::CMD_DISPATCH: scan_hit = 1'b1;
         cq_pkg::CMD_REMOVE:   scan_hit = (mem_rd_data.tag == tag_ff);
         default:              scan_hit = 1'b0;
      endcase
   end

   always_comb begin
      start_scan = 1'b0;
      if (req_take && !cnt_zero) begin
         case (req_cmd) inside
            cq_pkg::CMD_ADD:                         start_scan = !cnt_full;
            cq_pkg::CMD_DISPATCH, cq_pkg::CMD_REMOVE: start_scan = 1'b1;
            default:                                 start_scan = 1'b0;
         endcase
      end
   end

   // memory port control
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = '0;
      mem_wr_data = mem_rd_data;
      unique case (state_ff)
         S_IDLE: begin
            mem_rd_en = start_scan;
         end
         S_SCAN: begin
            if (scan_hit && cmd_ff == cq_pkg::CMD_ADD) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = cnt_less[cq_pkg::IDX_BITS-1:0];
            end else if (!scan_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_addr_ff + cq_pkg::IDX_BITS'(1);
            end
         end
         S_SHIFT_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_addr_ff + cq_pkg::IDX_BITS'(1);
            if ({1'b0, rd_addr_ff} != pos_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_addr_ff - cq_pkg::IDX_BITS'(1);
            end
         end
         S_SHIFT_DN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_addr_ff - cq_pkg::IDX_BITS'(1);
            if (!scan_last) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = rd_addr_ff + cq_pkg::IDX_BITS'(1);
            end
         end
         S_PLACE: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = pos_ff[cq_pkg::IDX_BITS-1:0];
            mem_wr_data = new_entry;
         end
         S_DONE: begin
            mem_rd_en = 1'b0;
         end
         default: begin
            mem_rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (mem_rd_en) begin
            rd_addr_ff <= mem_rd_addr;
         end
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_take) begin
                  cmd_ff        <= req_cmd;
                  sec_ff        <= req_sector;
                  wr_ff         <= req_is_write;
                  tag_ff        <= req_tag;
                  above_ff      <= (req_sector >= head_ff);
                  res_tag_ff    <= req_tag;
                  res_sector_ff <= '0;
                  res_write_ff  <= 1'b0;
                  res_occ_ff    <= cnt_ff;
                  unique case (req_cmd)
                     cq_pkg::CMD_ADD: begin
                        if (cnt_full) begin
                           res_status_ff <= cq_pkg::ST_FULL;
                           state_ff      <= S_DONE;
                        end else if (cnt_zero) begin
                           pos_ff   <= '0;
                           state_ff <= S_PLACE;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     cq_pkg::CMD_DISPATCH: begin
                        res_tag_ff <= '0;
                        if (cnt_zero) begin
                           res_status_ff <= cq_pkg::ST_EMPTY;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     cq_pkg::CMD_REMOVE: begin
                        if (cnt_zero) begin
                           res_status_ff <= cq_pkg::ST_NOT_FOUND;
                           state_ff      <= S_DONE;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                     cq_pkg::CMD_NONE: begin
                        res_tag_ff    <= '0;
                        res_status_ff <= cq_pkg::ST_ADDED;
                        state_ff      <= S_DONE;
                     end
                  endcase
               end
            end
            S_SCAN: begin
               if (scan_hit) begin
                  pos_ff <= {1'b0, rd_addr_ff};
                  if (cmd_ff == cq_pkg::CMD_ADD) begin
                     state_ff <= S_SHIFT_UP;
                  end else begin
                     if (cmd_ff == cq_pkg::CMD_DISPATCH) begin
                        res_status_ff <= cq_pkg::ST_DISPATCHED;
                        res_tag_ff    <= mem_rd_data.tag;
                        res_sector_ff <= mem_rd_data.sector;
                        res_write_ff  <= mem_rd_data.is_write;
                        head_ff       <= mem_rd_data.sector;
                     end else begin
                        res_status_ff <= cq_pkg::ST_ADDED;
                     end
                     if (scan_last) begin
                        cnt_ff     <= cnt_less;
                        res_occ_ff <= cnt_less;
                        state_ff   <= S_DONE;
                     end else begin
                        state_ff <= S_SHIFT_DN;
                     end
                  end
               end else if (scan_last) begin
                  if (cmd_ff == cq_pkg::CMD_ADD) begin
                     pos_ff   <= cnt_ff;
                     state_ff <= S_PLACE;
                  end else begin
                     res_status_ff <= cq_pkg::ST_NOT_FOUND;
                     state_ff      <= S_DONE;
                  end
               end
            end
            S_SHIFT_UP: begin
               if ({1'b0, rd_addr_ff} == pos_ff) begin
                  state_ff <= S_PLACE;
               end
            end
            S_SHIFT_DN: begin
               if (scan_last) begin
                  cnt_ff     <= cnt_less;
                  res_occ_ff <= cnt_less;
                  state_ff   <= S_DONE;
               end
            end
            S_PLACE: begin
               cnt_ff        <= cnt_more;
               res_occ_ff    <= cnt_more;
               res_status_ff <= cq_pkg::ST_ADDED;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_tag_ff    <= res_tag_ff;
                  rsp_sector_ff <= res_sector_ff;
                  rsp_write_ff  <= res_write_ff;
                  rsp_occ_ff    <= res_occ_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_tag      = rsp_tag_ff;
   assign rsp_out_sector   = rsp_sector_ff;
   assign rsp_out_is_write = rsp_write_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the c-look request scheduler, with random beats and stalls
`timescale 1ns / 1ps

module tb_top;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MAX_REPORTS    = 10;
   localparam int RANDOM_ITEMS   = 925;

   typedef struct packed {
      cq_pkg::cmd_type                cmd;
      logic [cq_pkg::SECTOR_BITS-1:0] sector;
      logic                           is_write;
      logic [cq_pkg::TAG_BITS-1:0]    tag;
   } request_type;

   typedef struct packed {
      cq_pkg::status_type             status;
      logic [cq_pkg::TAG_BITS-1:0]    tag;
      logic [cq_pkg::SECTOR_BITS-1:0] sector;
      logic                           is_write;
      logic [cq_pkg::CNT_BITS-1:0]    occupancy;
   } reply_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [1:0]                     req_command = cq_pkg::CMD_NONE;
   logic [cq_pkg::SECTOR_BITS-1:0] req_sector = '0;
   logic                           req_is_write = 1'b0;
   logic [cq_pkg::TAG_BITS-1:0]    req_tag = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [2:0]                     rsp_status;
   logic [cq_pkg::TAG_BITS-1:0]    rsp_out_tag;
   logic [cq_pkg::SECTOR_BITS-1:0] rsp_out_sector;
   logic                           rsp_out_is_write;
   logic [cq_pkg::CNT_BITS-1:0]    rsp_occupancy;

   request_type queued_requests[$];
   reply_type   awaited_replies[$];

   // shadow of the queue in c-look order, front at index 0
   cq_pkg::entry_type              slots [cq_pkg::QUEUE_DEPTH];
   int                             used = 0;
   logic [cq_pkg::SECTOR_BITS-1:0] head = '0;

   logic req_taken = 1'b0;
   bit   calm;
   int   accepted_count = 0;
   int   checked_count = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;
   int   seen_status [8];

   clook_request_scheduler DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sector       (req_sector),
      .req_is_write     (req_is_write),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_out_tag      (rsp_out_tag),
      .rsp_out_sector   (rsp_out_sector),
      .rsp_out_is_write (rsp_out_is_write),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // no idling on either side through a stretch of the run
   assign calm = (accepted_count >= 420) && (accepted_count < 580);

   function automatic void drop_slot(int pos);
      int i;
      for (i = pos; i + 1 < used; i++)
         slots[i] = slots[i + 1];
      used--;
   endfunction

   function automatic reply_type clook_reply(request_type r);
      reply_type o;
      int        pos;
      int        i;
      logic      stop;
      o = '0;
      o.status = cq_pkg::ST_ADDED;
      case (r.cmd)
         cq_pkg::CMD_ADD: begin
            o.tag = r.tag;
            if (used >= cq_pkg::QUEUE_DEPTH) begin
               o.status = cq_pkg::ST_FULL;
            end else begin
               pos = used;
               for (i = 0; i < used; i++) begin
                  if (pos == used) begin
                     if (r.sector >= head)
                        stop = (slots[i].sector < head) || (slots[i].sector > r.sector);
                     else
                        stop = (slots[i].sector < head) && (slots[i].sector > r.sector);
                     if (stop)
                        pos = i;
                  end
               end
               for (i = used; i > pos; i--)
                  slots[i] = slots[i - 1];
               slots[pos].sector   = r.sector;
               slots[pos].tag      = r.tag;
               slots[pos].is_write = r.is_write;
               used++;
            end
         end
         cq_pkg::CMD_DISPATCH: begin
            if (used == 0) begin
               o.status = cq_pkg::ST_EMPTY;
            end else begin
               o.status   = cq_pkg::ST_DISPATCHED;
               o.tag      = slots[0].tag;
               o.sector   = slots[0].sector;
               o.is_write = slots[0].is_write;
               head       = slots[0].sector;
               drop_slot(0);
            end
         end
         cq_pkg::CMD_REMOVE: begin
            o.tag    = r.tag;
            o.status = cq_pkg::ST_NOT_FOUND;
            pos      = -1;
            for (i = 0; i < used; i++)
               if (pos < 0 && slots[i].tag == r.tag)
                  pos = i;
            if (pos >= 0) begin
               drop_slot(pos);
               o.status = cq_pkg::ST_ADDED;
            end
         end
         default: ;
      endcase
      o.occupancy = cq_pkg::CNT_BITS'(used);
      return o;
   endfunction

   task automatic push_req(cq_pkg::cmd_type cmd, logic [cq_pkg::SECTOR_BITS-1:0] sector,
                           logic is_write, logic [cq_pkg::TAG_BITS-1:0] tag);
      request_type r;
      r.cmd      = cmd;
      r.sector   = sector;
      r.is_write = is_write;
      r.tag      = tag;
      queued_requests.push_back(r);
   endtask

   // driver
   always @(negedge clock) begin
      request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (queued_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 30)) begin
            next_req = queued_requests.pop_front();
            req_valid    <= 1'b1;
            req_command  <= next_req.cmd;
            req_sector   <= next_req.sector;
            req_is_write <= next_req.is_write;
            req_tag      <= next_req.tag;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= !reset && !calm && ($urandom_range(0, 99) < 30);
   end

   // accepted request beats feed the predictor
   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            r.cmd      = cq_pkg::cmd_type'(req_command);
            r.sector   = req_sector;
            r.is_write = req_is_write;
            r.tag      = req_tag;
            awaited_replies.push_back(clook_reply(r));
            accepted_count++;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         checked_count++;
         seen_status[rsp_status]++;
         if (awaited_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected reply: status %0d tag %0h sector %0h wr %0b occ %0d",
                        rsp_status, rsp_out_tag, rsp_out_sector, rsp_out_is_write,
                        rsp_occupancy);
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_status !== want.status || rsp_out_tag !== want.tag ||
                rsp_out_sector !== want.sector || rsp_out_is_write !== want.is_write ||
                rsp_occupancy !== want.occupancy) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("reply %0d expected: status %0d tag %0h sector %0h wr %0b occ %0d",
                           checked_count, want.status, want.tag, want.sector, want.is_write,
                           want.occupancy);
                  $display("reply %0d actual:   status %0d tag %0h sector %0h wr %0b occ %0d",
                           checked_count, rsp_status, rsp_out_tag, rsp_out_sector,
                           rsp_out_is_write, rsp_occupancy);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                             n;
      int                             roll;
      bit                             filling;
      cq_pkg::cmd_type                cmd;
      logic [cq_pkg::SECTOR_BITS-1:0] sector;
      logic [cq_pkg::TAG_BITS-1:0]    tag;

      // empty queue, unknown tag, unused command
      push_req(cq_pkg::CMD_DISPATCH, '1, 1'b1, 8'hff);
      push_req(cq_pkg::CMD_REMOVE, '0, 1'b0, 8'ha5);
      push_req(cq_pkg::CMD_NONE, '1, 1'b1, 8'hff);
      // fill to the top with extremes, equal sectors and repeated tags
      for (n = 0; n < cq_pkg::QUEUE_DEPTH; n++) begin
         if (n == 0)
            sector = '0;
         else if (n == 1)
            sector = '1;
         else if (n == 4 || n == 6)
            sector = 48'd100;
         else
            sector = cq_pkg::SECTOR_BITS'((n * 37) % 11 * 1000);
         if (n == 2 || n == 5)
            tag = 8'd9;
         else if (n == 3)
            tag = 8'h00;
         else if (n == 4)
            tag = 8'hff;
         else
            tag = cq_pkg::TAG_BITS'(n + 16);
         push_req(cq_pkg::CMD_ADD, sector, n[0], tag);
      end
      push_req(cq_pkg::CMD_ADD, 48'd5, 1'b1, 8'h77);
      push_req(cq_pkg::CMD_REMOVE, '0, 1'b0, 8'd9);
      push_req(cq_pkg::CMD_REMOVE, '0, 1'b0, 8'hee);
      push_req(cq_pkg::CMD_DISPATCH, '0, 1'b0, 8'h00);
      push_req(cq_pkg::CMD_DISPATCH, '0, 1'b0, 8'h00);
      push_req(cq_pkg::CMD_DISPATCH, '0, 1'b0, 8'h00);

      // random part, alternating phases that fill and drain the queue
      filling = 1'b0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0)
            filling = !filling;
         roll = $urandom_range(0, 99);
         if (filling) begin
            if (roll < 68)      cmd = cq_pkg::CMD_ADD;
            else if (roll < 88) cmd = cq_pkg::CMD_DISPATCH;
            else if (roll < 97) cmd = cq_pkg::CMD_REMOVE;
            else                cmd = cq_pkg::CMD_NONE;
         end else begin
            if (roll < 25)      cmd = cq_pkg::CMD_ADD;
            else if (roll < 78) cmd = cq_pkg::CMD_DISPATCH;
            else if (roll < 97) cmd = cq_pkg::CMD_REMOVE;
            else                cmd = cq_pkg::CMD_NONE;
         end
         case ($urandom_range(0, 9))
            0, 1, 2: sector = cq_pkg::SECTOR_BITS'($urandom_range(0, 63));
            3, 4, 5: sector = cq_pkg::SECTOR_BITS'({$urandom, $urandom});
            6:       sector = '1;
            7:       sector = '0;
            default: sector = '1 - cq_pkg::SECTOR_BITS'($urandom_range(0, 63));
         endcase
         if ($urandom_range(0, 9) < 8)
            tag = cq_pkg::TAG_BITS'($urandom_range(0, 15));
         else
            tag = cq_pkg::TAG_BITS'($urandom_range(0, 255));
         push_req(cmd, sector, 1'($urandom_range(0, 1)), tag);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (queued_requests.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("%0d requests sent, %0d replies checked, %0d mismatches",
               accepted_count, checked_count, mismatches);
      $display("dispatched %0d, empty %0d, full %0d, tag not found %0d",
               seen_status[cq_pkg::ST_DISPATCHED], seen_status[cq_pkg::ST_EMPTY],
               seen_status[cq_pkg::ST_FULL], seen_status[cq_pkg::ST_NOT_FOUND]);
      if (mismatches == 0 && awaited_replies.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
